// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the dual ring buffer checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define AST_IMPLY(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define AST_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/udrb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udrb_pkg
// types and constants shared by the dual ring buffer and its checker
// ----------------------------------------------------------------------------
package udrb_pkg;

	// default ring depths
	localparam int TX_DEPTH_DEF = 64;
	localparam int RX_DEPTH_DEF = 64;

	// field widths
	localparam int CMD_W   = 3;
	localparam int DATA_W  = 8;
	localparam int COUNT_W = 6;

	// command codes
	typedef enum logic [CMD_W-1:0] {
		CMD_HOST_WR  = 3'd0,
		CMD_HOST_RD  = 3'd1,
		CMD_LINE_RX  = 3'd2,
		CMD_TX_READY = 3'd3,
		CMD_CLEAR    = 3'd4
	} cmd_t;

endpackage

// File: hdl/uart_dual_ring_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_dual_ring_buffer
// transmit and receive byte rings for a uart, one command per transaction
// ----------------------------------------------------------------------------
//
// channel   handshake            payload
// -------   ------------------   -------------------------------------------
// command   start, busy          cmd, data_in
// result    done (strobe)        byte_out, byte_valid, accepted, rx_count,
//                                rx_front, rx_empty, tx_irq_enable
//
// one command is taken in every cycle; busy stays low.
// each result shows on the result ports in the cycle after its command,
// for exactly one cycle, marked by done; the receiver cannot stall.
// pointers and the irq enable update at the command edge; the store reads
// (pop and front peek) are registered into the result cycle.
// arst_n clears the ring pointers, the irq enable and the result strobe;
// the byte stores are not cleared.
// ----------------------------------------------------------------------------
module uart_dual_ring_buffer #(
	parameter int TX_DEPTH = udrb_pkg::TX_DEPTH_DEF,
	parameter int RX_DEPTH = udrb_pkg::RX_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [udrb_pkg::CMD_W-1:0]   cmd,
	input  logic [udrb_pkg::DATA_W-1:0]  data_in,
	output logic                         done,
	output logic [udrb_pkg::DATA_W-1:0]  byte_out,
	output logic                         byte_valid,
	output logic                         accepted,
	output logic [udrb_pkg::COUNT_W-1:0] rx_count,
	output logic [udrb_pkg::DATA_W-1:0]  rx_front,
	output logic                         rx_empty,
	output logic                         tx_irq_enable
);

	localparam int TX_AW = $clog2(TX_DEPTH);
	localparam int RX_AW = $clog2(RX_DEPTH);
	localparam int CNT_W = (RX_AW + 1 > udrb_pkg::COUNT_W) ? RX_AW + 1 : udrb_pkg::COUNT_W;

	// stores
	logic [udrb_pkg::DATA_W-1:0] tx_mem [TX_DEPTH];
	logic [udrb_pkg::DATA_W-1:0] rx_mem [RX_DEPTH];

	// pointer and enable state
	logic [TX_AW-1:0] tx_wr_q, tx_rd_q, tx_wr_d, tx_rd_d, tx_wr_nxt, tx_rd_nxt;
	logic [RX_AW-1:0] rx_wr_q, rx_rd_q, rx_wr_d, rx_rd_d, rx_wr_nxt, rx_rd_nxt;
	logic             irq_q, irq_d;

	// per-command control
	udrb_pkg::cmd_t cmd_c;
	logic           accept;
	logic           tx_we, rx_we, pop_tx, pop_rx, acc_c, bypass_c;

	// result registers
	logic                        done_q, valid_q, acc_q, pop_tx_q, bypass_q;
	logic [udrb_pkg::DATA_W-1:0] tx_pop_q, rx_pop_q, rx_peek_q, data_q;
	logic [CNT_W-1:0]            rx_diff;

	assign busy   = 1'b0;
	assign accept = start & ~busy;
	assign cmd_c  = udrb_pkg::cmd_t'(cmd);

	// ring pointer advance with wrap at depth
	assign tx_wr_nxt = (tx_wr_q == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_wr_q + 1'b1;
	assign tx_rd_nxt = (tx_rd_q == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_rd_q + 1'b1;
	assign rx_wr_nxt = (rx_wr_q == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_wr_q + 1'b1;
	assign rx_rd_nxt = (rx_rd_q == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_rd_q + 1'b1;

	// command decode and next state
	always_comb begin
		tx_wr_d  = tx_wr_q;
		tx_rd_d  = tx_rd_q;
		rx_wr_d  = rx_wr_q;
		rx_rd_d  = rx_rd_q;
		irq_d    = irq_q;
		tx_we    = 1'b0;
		rx_we    = 1'b0;
		pop_tx   = 1'b0;
		pop_rx   = 1'b0;
		acc_c    = 1'b0;
		if (accept) begin
			unique case (cmd_c)
				udrb_pkg::CMD_HOST_WR: begin
					if (tx_wr_nxt != tx_rd_q) begin
						tx_we   = 1'b1;
						tx_wr_d = tx_wr_nxt;
						irq_d   = 1'b1;
						acc_c   = 1'b1;
					end
				end
				udrb_pkg::CMD_HOST_RD: begin
					if (rx_wr_q != rx_rd_q) begin
						pop_rx  = 1'b1;
						rx_rd_d = rx_rd_nxt;
					end
				end
				udrb_pkg::CMD_LINE_RX: begin
					if (rx_wr_nxt != rx_rd_q) begin
						rx_we   = 1'b1;
						rx_wr_d = rx_wr_nxt;
						acc_c   = 1'b1;
					end
				end
				udrb_pkg::CMD_TX_READY: begin
					if (tx_wr_q == tx_rd_q) begin
						irq_d = 1'b0;
					end else begin
						pop_tx  = 1'b1;
						tx_rd_d = tx_rd_nxt;
					end
				end
				udrb_pkg::CMD_CLEAR: begin
					tx_wr_d = '0;
					tx_rd_d = '0;
					rx_wr_d = '0;
					rx_rd_d = '0;
				end
				default: begin
				end
			endcase
		end
	end

	// a byte landing in an empty receive ring is the new front
	assign bypass_c = rx_we & (rx_wr_q == rx_rd_q);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_wr_q  <= '0;
			tx_rd_q  <= '0;
			rx_wr_q  <= '0;
			rx_rd_q  <= '0;
			irq_q    <= 1'b0;
			done_q   <= 1'b0;
			valid_q  <= 1'b0;
			acc_q    <= 1'b0;
			pop_tx_q <= 1'b0;
			bypass_q <= 1'b0;
		end else begin
			tx_wr_q  <= tx_wr_d;
			tx_rd_q  <= tx_rd_d;
			rx_wr_q  <= rx_wr_d;
			rx_rd_q  <= rx_rd_d;
			irq_q    <= irq_d;
			done_q   <= accept;
			valid_q  <= pop_tx | pop_rx;
			acc_q    <= acc_c;
			pop_tx_q <= pop_tx;
			bypass_q <= bypass_c;
		end
	end

	// transmit store: one write, one registered pop read
	always_ff @(posedge clk) begin
		if (tx_we) begin
			tx_mem[tx_wr_q] <= data_in;
		end
		tx_pop_q <= tx_mem[tx_rd_q];
	end

	// receive store: one write, registered pop and front reads
	always_ff @(posedge clk) begin
		if (rx_we) begin
			rx_mem[rx_wr_q] <= data_in;
		end
		rx_pop_q  <= rx_mem[rx_rd_q];
		rx_peek_q <= rx_mem[rx_rd_d];
	end

	// byte held for the front bypass
	always_ff @(posedge clk) begin
		data_q <= data_in;
	end

	// receive fill level from the post-command pointers
	assign rx_diff = CNT_W'(rx_wr_q) - CNT_W'(rx_rd_q)
		+ ((rx_wr_q < rx_rd_q) ? CNT_W'(RX_DEPTH) : '0);

	// result ports
	assign done          = done_q;
	assign byte_valid    = valid_q;
	assign accepted      = acc_q;
	assign byte_out      = valid_q ? (pop_tx_q ? tx_pop_q : rx_pop_q) : '0;
	assign rx_empty      = (rx_wr_q == rx_rd_q);
	assign rx_count      = rx_diff[udrb_pkg::COUNT_W-1:0];
	assign rx_front      = rx_empty ? '0 : (bypass_q ? data_q : rx_peek_q);
	assign tx_irq_enable = irq_q;

endmodule

// File: hdl/udrb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udrb_checker
// port-level checks on the dual ring buffer, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module udrb_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic [udrb_pkg::CMD_W-1:0]   cmd,
	input logic                         done,
	input logic                         byte_valid,
	input logic                         accepted,
	input logic [udrb_pkg::COUNT_W-1:0] rx_count,
	input logic [udrb_pkg::DATA_W-1:0]  rx_front,
	input logic                         rx_empty,
	input logic                         tx_irq_enable
);

	logic take;
	logic host_wr;
	logic rx_idle;

	// command transaction, host write transaction and idle receive status
	assign take    = start && !busy;
	assign host_wr = take && (cmd == udrb_pkg::CMD_HOST_WR);
	assign rx_idle = (rx_count == '0) && (rx_front == '0);

	// every transaction gives one result in the next cycle, no extra ones
	`AST_NEXT(a_done_follows, clk, arst_n, take, done, "no result after command")
	`AST_NEXT(a_no_spurious, clk, arst_n, !take, !done, "result without command")

	// an empty receive ring reports no level and no front byte
	`AST_IMPLY(a_empty_status, clk, arst_n, done && rx_empty, rx_idle, "empty ring status mismatch")

	// a stored host write leaves the transmit irq enabled
	`AST_NEXT(a_wr_sets_irq, clk, arst_n, host_wr, !accepted || tx_irq_enable, "write without irq")

	// a pop never also reports a store
	`AST_IMPLY(a_pop_not_store, clk, arst_n, done && byte_valid, !accepted, "pop and store in one result")

endmodule

bind uart_dual_ring_buffer udrb_checker u_udrb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.cmd           (cmd),
	.done          (done),
	.byte_valid    (byte_valid),
	.accepted      (accepted),
	.rx_count      (rx_count),
	.rx_front      (rx_front),
	.rx_empty      (rx_empty),
	.tx_irq_enable (tx_irq_enable)
);
